[rtl/bcsh_pkg.sv]
`timescale 1ns / 1ps

package bcsh_pkg;

	// fixed field widths
	localparam int MOM_BIN_W  = 4;
	localparam int MASS_BIN_W = 5;
	localparam int TABLE_BINS = 10;

	// mass binning: 12 MeV steps from 1750 MeV, divide by 12 through a reciprocal
	localparam logic [11:0] MASS_LOW_MEV  = 12'd1750;
	localparam logic [11:0] MASS_RECIP_12 = 12'd2731;  // ceil(2^15 / 12)
	localparam int          MASS_RECIP_SH = 15;

	typedef enum logic [1:0] {
		CMD_CAND  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		REG_ETA_LIMIT    = 2'd0,
		REG_WANTED_TYPE  = 2'd1,
		REG_MIN_MOMENTUM = 2'd2
	} cfg_reg_e;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_READ,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] momentum;
		logic [11:0] pseudorapidity;
		logic [11:0] mass_mev;
		logic [3:0]  cand_kind;
		logic [15:0] pointing_angle;
		logic [15:0] vertex_prob;
		logic [15:0] flight_signif;
		logic [8:0]  entry_index;
	} in_item_t;

	typedef struct packed {
		logic                  accepted;
		logic [MOM_BIN_W-1:0]  momentum_bin;
		logic [MASS_BIN_W-1:0] mass_bin;
		logic [31:0]           count_value;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] value;
	} cfg_wr_t;

	// controller to datapath
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic update;
		logic clr_step;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
	} dp_status_t;

	// momentum edges in 1/16 GeV
	localparam logic [15:0] EDGE_TAB [TABLE_BINS] = '{
		16'd56, 16'd72, 16'd88, 16'd112, 16'd144,
		16'd176, 16'd208, 16'd256, 16'd320, 16'd448
	};

	// per-bin cuts, already in input units
	localparam logic [15:0] ANGLE_BELOW [TABLE_BINS] = '{
		16'd918, 16'd918, 16'd787, 16'd984, 16'd1033,
		16'd934, 16'd869, 16'd967, 16'd967, 16'd689
	};
	localparam logic [15:0] PROB_ABOVE [TABLE_BINS] = '{
		16'd17498, 16'd17498, 16'd13697, 16'd7405, 16'd6094,
		16'd3735, 16'd49152, 16'd1638, 16'd44564, 16'd1179
	};
	localparam logic [15:0] SIGNIF_ABOVE [TABLE_BINS] = '{
		16'd975, 16'd975, 16'd1000, 16'd1003, 16'd965,
		16'd913, 16'd862, 16'd737, 16'd693, 16'd673
	};

endpackage

[rtl/bcsh_stream_if.sv]
`timescale 1ns / 1ps

interface bcsh_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/bcsh_ctrl.sv]
`timescale 1ns / 1ps

module bcsh_ctrl import bcsh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cand_valid,
	output logic       cand_ready,
	output logic       res_valid,
	input  logic       res_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   out_free;

	// output register can take a new result this cycle
	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cand_valid)
					state_d = ST_CALC;
			end
			ST_CALC:   state_d = ST_READ;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (out_free)
					state_d = cand_valid ? ST_CALC : ST_IDLE;
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cand_ready   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				cand_ready = 1'b1;
			end
			ST_CALC: begin
				cmd.load_s2 = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = out_free;
				cand_ready = out_free;
			end
			default: begin
				cand_ready = 1'b0;
			end
		endcase
		cmd.load_s1 = cand_ready && cand_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

[rtl/bcsh_datapath.sv]
`timescale 1ns / 1ps

module bcsh_datapath import bcsh_pkg::*; #(
	parameter int MOMENTUM_BINS = 10,
	parameter int MASS_BINS     = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status,
	input  in_item_t   cand_data,
	input  logic       cfg_we,
	input  cfg_wr_t    cfg_data,
	output out_item_t  res_data
);

	localparam int SLOTS   = MASS_BINS + 2;
	localparam int DEPTH   = MOMENTUM_BINS * SLOTS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int MBW     = $clog2(SLOTS);
	localparam int N_EDGES = (MOMENTUM_BINS < TABLE_BINS) ? MOMENTUM_BINS : TABLE_BINS;

	// configuration registers
	logic [10:0] eta_limit_q;
	logic [3:0]  wanted_type_q;
	logic [15:0] min_mom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_limit_q   <= 11'd256;
			wanted_type_q <= 4'd2;
			min_mom_q     <= 16'd56;
		end else if (cfg_we) begin
			case (cfg_data.index)
				REG_ETA_LIMIT:    eta_limit_q   <= cfg_data.value[10:0];
				REG_WANTED_TYPE:  wanted_type_q <= cfg_data.value[3:0];
				REG_MIN_MOMENTUM: min_mom_q     <= cfg_data.value;
				default:          ;
			endcase
		end
	end

	// stage 1: captured item
	in_item_t item_s1;

	always_ff @(posedge clk) begin
		if (cmd.load_s1)
			item_s1 <= cand_data;
	end

	// candidate momentum bin
	logic [N_EDGES-1:0]   above_edge;
	logic [MOM_BIN_W-1:0] edge_cnt;
	logic [MOM_BIN_W-1:0] cand_pbin;

	always_comb begin
		for (int k = 0; k < N_EDGES; k++)
			above_edge[k] = EDGE_TAB[k] < item_s1.momentum;
		edge_cnt  = MOM_BIN_W'($countones(above_edge));
		cand_pbin = (edge_cnt == '0) ? '0 : edge_cnt - 1'b1;
	end

	// candidate mass bin
	logic [11:0]    mass_off;
	logic [23:0]    mass_prod;
	logic [7:0]     mass_q;
	logic [MBW-1:0] cand_mbin;

	always_comb begin
		mass_off  = item_s1.mass_mev - MASS_LOW_MEV;
		mass_prod = {12'd0, mass_off} * {12'd0, MASS_RECIP_12};
		mass_q    = mass_prod[MASS_RECIP_SH +: 8];
		if (item_s1.mass_mev < MASS_LOW_MEV)
			cand_mbin = '0;
		else if (mass_q >= 8'(MASS_BINS))
			cand_mbin = MBW'(MASS_BINS + 1);
		else
			cand_mbin = MBW'(mass_q + 8'd1);
	end

	// cuts
	logic [11:0] eta_abs;
	logic        cand_pass;

	always_comb begin
		eta_abs   = item_s1.pseudorapidity[11] ? 12'(~item_s1.pseudorapidity + 12'd1)
		                                       : item_s1.pseudorapidity;
		cand_pass = (item_s1.momentum >= min_mom_q)
		         && (eta_abs < {1'b0, eta_limit_q})
		         && (item_s1.cand_kind == wanted_type_q)
		         && (item_s1.pointing_angle < ANGLE_BELOW[cand_pbin])
		         && (item_s1.vertex_prob > PROB_ABOVE[cand_pbin])
		         && (item_s1.flight_signif > SIGNIF_ABOVE[cand_pbin]);
	end

	// entry index decode for read and clear
	logic [MOMENTUM_BINS-1:0] idx_ge;
	logic                     idx_ok;
	logic [MOM_BIN_W-1:0]     idx_pbin;
	logic [MBW-1:0]           idx_mbin;

	always_comb begin
		idx_ge[0] = 1'b0;
		for (int k = 1; k < MOMENTUM_BINS; k++)
			idx_ge[k] = 32'(item_s1.entry_index) >= 32'(k * SLOTS);
		idx_ok   = 32'(item_s1.entry_index) < 32'(DEPTH);
		idx_pbin = MOM_BIN_W'($countones(idx_ge));
		idx_mbin = MBW'(32'(item_s1.entry_index) - 32'(idx_pbin) * 32'(SLOTS));
	end

	// stage 2: decoded operation
	logic              inc_s2;
	logic              rd_s2;
	logic              clr_s2;
	logic [MOM_BIN_W-1:0] pbin_s2;
	logic [MBW-1:0]    mbin_s2;
	logic [ADDR_W-1:0] addr_s2;

	always_ff @(posedge clk) begin
		if (cmd.load_s2) begin
			inc_s2  <= 1'b0;
			rd_s2   <= 1'b0;
			clr_s2  <= 1'b0;
			pbin_s2 <= '0;
			mbin_s2 <= '0;
			addr_s2 <= '0;
			case (item_s1.command)
				CMD_CAND: begin
					inc_s2  <= cand_pass;
					pbin_s2 <= cand_pbin;
					mbin_s2 <= cand_mbin;
					addr_s2 <= ADDR_W'(32'(cand_pbin) * 32'(SLOTS) + 32'(cand_mbin));
				end
				CMD_READ, CMD_CLEAR: begin
					if (idx_ok) begin
						rd_s2   <= 1'b1;
						clr_s2  <= (item_s1.command == CMD_CLEAR);
						pbin_s2 <= idx_pbin;
						mbin_s2 <= idx_mbin;
						addr_s2 <= ADDR_W'(item_s1.entry_index);
					end
				end
				default: ;
			endcase
		end
	end

	// histogram store and clearing sweep
	logic [31:0]       hist_mem [DEPTH];
	logic [31:0]       rd_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [31:0]       cnt_inc;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [31:0]       mem_wdata;

	assign status.clr_last = clr_addr_q == ADDR_W'(DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clr_step && !status.clr_last)
			clr_addr_q <= clr_addr_q + 1'b1;
	end

	// saturating increment
	assign cnt_inc = (rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1;

	always_comb begin
		mem_we    = cmd.clr_step || (cmd.update && (inc_s2 || clr_s2));
		mem_waddr = cmd.clr_step ? clr_addr_q : addr_s2;
		mem_wdata = (cmd.update && inc_s2) ? cnt_inc : 32'd0;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			hist_mem[mem_waddr] <= mem_wdata;
		rd_q <= hist_mem[addr_s2];
	end

	// result register
	out_item_t res_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_q.accepted     <= inc_s2;
			res_q.momentum_bin <= pbin_s2;
			res_q.mass_bin     <= MASS_BIN_W'(mbin_s2);
			if (inc_s2)
				res_q.count_value <= cnt_inc;
			else if (rd_s2)
				res_q.count_value <= rd_q;
			else
				res_q.count_value <= 32'd0;
		end
	end

	assign res_data = res_q;

endmodule

[rtl/binned_cut_selector_histogram_top.sv]
`timescale 1ns / 1ps
// flow: calc, read and update, one item at a time, since the histogram
//   read-modify-write (decode, memory read, write back) is done per item; the next
//   candidate is taken in update or idle; update waits on an untaken result
// reset: asynchronous, active low; after reset all MOMENTUM_BINS * (MASS_BINS + 2)
//   entries (270 by default) are swept to zero, one entry per cycle; no candidate
//   is taken meanwhile; configuration writes are taken at any time

module binned_cut_selector_histogram_top import bcsh_pkg::*; #(
	parameter int MOMENTUM_BINS = 10,
	parameter int MASS_BINS     = 25
) (
	input logic         clk,
	input logic         arst_n,
	bcsh_stream_if.sink   cand,
	bcsh_stream_if.source result,
	bcsh_stream_if.sink   cfg
);

	ctrl_cmd_t  cmd;
	dp_status_t status;
	out_item_t  res_data;
	logic       res_valid;
	logic       cand_ready;

	// register writes never stall
	assign cfg.ready = 1'b1;

	// sequencer: clearing sweep, then one item at a time through calc, read, update
	bcsh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand.valid),
		.cand_ready (cand_ready),
		.res_valid  (res_valid),
		.res_ready  (result.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// binning, cuts, histogram memory and result register
	bcsh_datapath #(
		.MOMENTUM_BINS (MOMENTUM_BINS),
		.MASS_BINS     (MASS_BINS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cand_data (cand.data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.res_data  (res_data)
	);

	// a finished result waits in the output register while the next
	// candidate transfer is taken in the update cycle
	assign cand.ready   = cand_ready;
	assign result.valid = res_valid;
	assign result.data  = res_data;

endmodule
